FILE: design/knn_three_class_classifier_macros.svh
// assertion helpers shared by the classifier modules
`ifndef KNN_THREE_CLASS_CLASSIFIER_MACROS_SVH
`define KNN_THREE_CLASS_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define KNN3C_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("knn3c assertion failed");

// next-cycle implication, checked out of reset
`define KNN3C_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("knn3c assertion failed");

`endif

FILE: design/knn3c_pkg.sv
package knn3c_pkg;

    // default table depth
    localparam int NUM_REFS_DEF = 40;

    // field widths
    localparam int AMP_W       = 16;
    localparam int PER_W       = 16;
    localparam int CLS_W       = 2;
    localparam int IDX_PORT_W  = 6;
    localparam int K_W         = 6;
    localparam int LABEL_W     = 2;
    localparam int SCORE_OUT_W = 15;
    localparam int DIST_W      = 2 * AMP_W + 1;
    localparam int ENTRY_W     = AMP_W + PER_W + CLS_W;

    localparam int SCORE_OUT_MAX = 32767;

    localparam logic [K_W-1:0] K_RESET = 6'd7;

    // command codes
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // class codes of a reference point
    localparam logic [CLS_W-1:0] CLASS_NORMAL      = 2'd0;
    localparam logic [CLS_W-1:0] CLASS_ATRIAL      = 2'd1;
    localparam logic [CLS_W-1:0] CLASS_VENTRICULAR = 2'd2;

    // result labels
    localparam logic [LABEL_W-1:0] LABEL_UNKNOWN     = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_NORMAL      = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_ATRIAL      = 2'd2;
    localparam logic [LABEL_W-1:0] LABEL_VENTRICULAR = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic           ram_we;
        logic           capture;
        logic           rd_en;
        logic           vote_en;
        logic           finish;
        logic [K_W-1:0] rank;
    } knn3c_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_idle;
        logic out_free;
    } knn3c_stat_t;

endpackage

FILE: design/knn3c_ram.sv
module knn3c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/knn3c_ctrl.sv
`include "knn_three_class_classifier_macros.svh"

module knn3c_ctrl
    import knn3c_pkg::*;
#(
    parameter int NUM_REFS = NUM_REFS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [IDX_PORT_W-1:0]       s_entry_index,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [K_W-1:0]              cfg_data,
    output knn3c_cmd_t                  cmd_o,
    output logic [$clog2(NUM_REFS)-1:0] rd_addr_o,
    input  knn3c_stat_t                 stat_i
);

    localparam int IDX_W = $clog2(NUM_REFS);
    localparam int K_CAP = (NUM_REFS - 1 < 2**K_W - 1) ? NUM_REFS - 1 : 2**K_W - 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_REFS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_VOTE  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [K_W-1:0]   rank_reg, rank_next;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_eff;
    logic             accept;
    logic             in_range;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign in_range  = int'(s_entry_index) < NUM_REFS;
    assign k_eff     = (int'(k_reg) > K_CAP) ? K_W'(K_CAP) : k_reg;
    assign rd_addr_o = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else if (cfg_valid && cfg_ready) begin
            k_reg <= cfg_data;
        end
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        rank_next     = rank_reg;
        cmd_o         = '0;
        cmd_o.rank    = rank_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_command == CMD_LOAD) begin
                    cmd_o.ram_we = in_range;
                end else if (accept) begin
                    cmd_o.capture = 1'b1;
                    addr_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd_o.rd_en = 1'b1;
                addr_next   = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat_i.pipe_idle) begin
                    rank_next  = '0;
                    state_next = ST_VOTE;
                end
            end
            ST_VOTE: begin
                cmd_o.vote_en = 1'b1;
                rank_next     = rank_reg + 1'b1;
                if (rank_reg == k_eff) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd_o.finish = stat_i.out_free;
                if (stat_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rank_reg  <= rank_next;
        end
    end

    `KNN3C_ASSERT_NEXT(a_scan_to_drain, state_reg == ST_SCAN && addr_reg == LAST_ADDR,
        state_reg == ST_DRAIN)
    `KNN3C_ASSERT_IMP(a_vote_pipe_empty, state_reg == ST_VOTE, stat_i.pipe_idle)

endmodule

FILE: design/knn3c_dp.sv
`include "knn_three_class_classifier_macros.svh"

module knn3c_dp
    import knn3c_pkg::*;
#(
    parameter int NUM_REFS = NUM_REFS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  knn3c_cmd_t                  cmd_i,
    input  logic [$clog2(NUM_REFS)-1:0] rd_addr_i,
    output knn3c_stat_t                 stat_o,
    input  logic [IDX_PORT_W-1:0]       s_entry_index,
    input  logic [AMP_W-1:0]            s_amplitude,
    input  logic [PER_W-1:0]            s_rr_period,
    input  logic [CLS_W-1:0]            s_entry_class,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [LABEL_W-1:0]          m_class_label,
    output logic [SCORE_OUT_W-1:0]      m_normal_score,
    output logic [SCORE_OUT_W-1:0]      m_atrial_score,
    output logic [SCORE_OUT_W-1:0]      m_ventricular_score
);

    localparam int IDX_W    = $clog2(NUM_REFS);
    localparam int LIST_LEN = (NUM_REFS < 2**K_W) ? NUM_REFS : 2**K_W;
    localparam int K_MAX    = LIST_LEN - 1;
    localparam int SCORE_W  = $clog2(K_MAX * (K_MAX + 1) * (2 * K_MAX + 1) / 6 + 1);

    function automatic logic [SCORE_OUT_W-1:0] sat_score(input logic [SCORE_W-1:0] s);
        logic [SCORE_OUT_W-1:0] r;
        r = (int'(s) > SCORE_OUT_MAX) ? SCORE_OUT_W'(SCORE_OUT_MAX) : SCORE_OUT_W'(s);
        return r;
    endfunction

    // reference table
    logic [ENTRY_W-1:0] ram_rdata;

    knn3c_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_REFS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd_i.ram_we),
        .waddr (IDX_W'(s_entry_index)),
        .wdata ({s_amplitude, s_rr_period, s_entry_class}),
        .re    (cmd_i.rd_en),
        .raddr (rd_addr_i),
        .rdata (ram_rdata)
    );

    logic [AMP_W-1:0] samp_amp_reg;
    logic [PER_W-1:0] samp_per_reg;

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            samp_amp_reg <= s_amplitude;
            samp_per_reg <= s_rr_period;
        end
    end

    // distance pipeline: table read, squares, sum
    logic                 rd_v_reg, sq_v_reg, sum_v_reg;
    logic [AMP_W-1:0]     ref_amp, da;
    logic [PER_W-1:0]     ref_per, dp;
    logic [2*AMP_W-1:0]   sq_a_reg;
    logic [2*PER_W-1:0]   sq_p_reg;
    logic [CLS_W-1:0]     cls2_reg, cls3_reg;
    logic [DIST_W-1:0]    sum_reg;

    assign ref_amp = ram_rdata[ENTRY_W-1 -: AMP_W];
    assign ref_per = ram_rdata[CLS_W +: PER_W];
    assign da = (samp_amp_reg > ref_amp) ? samp_amp_reg - ref_amp : ref_amp - samp_amp_reg;
    assign dp = (samp_per_reg > ref_per) ? samp_per_reg - ref_per : ref_per - samp_per_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= cmd_i.rd_en;
            sq_v_reg  <= rd_v_reg;
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sq_a_reg <= da * da;
        sq_p_reg <= dp * dp;
        cls2_reg <= ram_rdata[CLS_W-1:0];
        sum_reg  <= {1'b0, sq_a_reg} + {1'b0, sq_p_reg};
        cls3_reg <= cls2_reg;
    end

    assign stat_o.pipe_idle = !rd_v_reg && !sq_v_reg && !sum_v_reg;

    // sorted neighbor list, closest at cell 0, ties keep table order
    logic [DIST_W-1:0] dist_reg [LIST_LEN];
    logic [CLS_W-1:0]  lcls_reg [LIST_LEN];
    logic [LIST_LEN-1:0] lval_reg;
    logic [LIST_LEN-1:0] keep;
    logic [LIST_LEN-1:0] prev_keep;
    logic [DIST_W-1:0] prev_dist [LIST_LEN];
    logic [CLS_W-1:0]  prev_cls  [LIST_LEN];
    logic [LIST_LEN-1:0] prev_val;
    logic [DIST_W-1:0] nxt_dist [LIST_LEN];
    logic [CLS_W-1:0]  nxt_cls  [LIST_LEN];
    logic [LIST_LEN-1:0] nxt_val;

    for (genvar g = 0; g < LIST_LEN; g++) begin : g_cell
        assign keep[g] = lval_reg[g] && (dist_reg[g] <= sum_reg);

        if (g == 0) begin : g_first
            assign prev_keep[g] = 1'b1;
            assign prev_dist[g] = sum_reg;
            assign prev_cls[g]  = cls3_reg;
            assign prev_val[g]  = 1'b1;
        end else begin : g_rest
            assign prev_keep[g] = keep[g-1];
            assign prev_dist[g] = dist_reg[g-1];
            assign prev_cls[g]  = lcls_reg[g-1];
            assign prev_val[g]  = lval_reg[g-1];
        end

        if (g == LIST_LEN - 1) begin : g_last
            assign nxt_dist[g] = dist_reg[g];
            assign nxt_cls[g]  = lcls_reg[g];
            assign nxt_val[g]  = 1'b0;
        end else begin : g_inner
            assign nxt_dist[g] = dist_reg[g+1];
            assign nxt_cls[g]  = lcls_reg[g+1];
            assign nxt_val[g]  = lval_reg[g+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lval_reg[g] <= 1'b0;
            end else if (cmd_i.capture) begin
                lval_reg[g] <= 1'b0;
            end else if (sum_v_reg && !keep[g]) begin
                lval_reg[g] <= prev_keep[g] ? 1'b1 : prev_val[g];
            end else if (cmd_i.vote_en) begin
                lval_reg[g] <= nxt_val[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (sum_v_reg && !keep[g]) begin
                dist_reg[g] <= prev_keep[g] ? sum_reg  : prev_dist[g];
                lcls_reg[g] <= prev_keep[g] ? cls3_reg : prev_cls[g];
            end else if (cmd_i.vote_en) begin
                dist_reg[g] <= nxt_dist[g];
                lcls_reg[g] <= nxt_cls[g];
            end
        end
    end

    // weighted vote, one rank per cycle off the list head
    logic [2*K_W-1:0]  rank_sq;
    logic [SCORE_W-1:0] add_val;
    logic [SCORE_W-1:0] norm_reg, atr_reg, vent_reg;

    assign rank_sq = cmd_i.rank * cmd_i.rank;
    assign add_val = SCORE_W'(rank_sq);

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            norm_reg <= '0;
            atr_reg  <= '0;
            vent_reg <= '0;
        end else if (cmd_i.vote_en && cmd_i.rank != '0) begin
            case (lcls_reg[0])
                CLASS_NORMAL:      norm_reg <= norm_reg + add_val;
                CLASS_ATRIAL:      atr_reg  <= atr_reg + add_val;
                CLASS_VENTRICULAR: vent_reg <= vent_reg + add_val;
                default: ;
            endcase
        end
    end

    // result register
    logic                   m_valid_reg;
    logic [LABEL_W-1:0]     label_reg;
    logic [SCORE_OUT_W-1:0] norm_out_reg, atr_out_reg, vent_out_reg;
    logic [LABEL_W-1:0]     label;

    always_comb begin
        if (norm_reg > atr_reg && norm_reg > vent_reg) begin
            label = LABEL_NORMAL;
        end else if (atr_reg > norm_reg && atr_reg > vent_reg) begin
            label = LABEL_ATRIAL;
        end else if (vent_reg > norm_reg && vent_reg > atr_reg) begin
            label = LABEL_VENTRICULAR;
        end else begin
            label = LABEL_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.finish) begin
            label_reg    <= label;
            norm_out_reg <= sat_score(norm_reg);
            atr_out_reg  <= sat_score(atr_reg);
            vent_out_reg <= sat_score(vent_reg);
        end
    end

    assign stat_o.out_free     = !m_valid_reg || m_ready;
    assign m_valid             = m_valid_reg;
    assign m_class_label       = label_reg;
    assign m_normal_score      = norm_out_reg;
    assign m_atrial_score      = atr_out_reg;
    assign m_ventricular_score = vent_out_reg;

    `KNN3C_ASSERT_IMP(a_vote_head_valid, cmd_i.vote_en, lval_reg[0])
    `KNN3C_ASSERT_IMP(a_no_insert_in_vote, sum_v_reg, !cmd_i.vote_en && !cmd_i.finish)

endmodule

FILE: design/knn_three_class_classifier.sv
// weighted k-nearest-neighbor classifier, three classes
// input channel (s_*): a load transfer (command 0) writes one reference point
//   into table slot entry_index; slots at or past NUM_REFS are dropped.
//   a classify transfer (command 1) ranks every table entry by squared distance
//   to the sample and votes rank*rank for ranks 1..k into the class scores
// result channel (m_*): one transfer per classify item, none per load item
// config channel (cfg_*): k_neighbors, always ready, write only while idle
// sequence: a load leaves s_ready high. a classify item holds s_ready low, and
//   m_valid rises at the edge that ends that stretch: the scan of all NUM_REFS
//   entries, a drain of the 3-stage distance pipeline into the sorted list, the
//   vote off the list head, rank by rank up to k, and the load of the output register
// overlap: a new classify item is taken only after the previous one has
//   reached the output register
// stall: the result sits in an output register; a new item is taken while it
//   waits, and the next result holds in the score registers, with s_ready low,
//   until m_ready frees the output register
// reset: aresetn is synchronous, active low; k returns to 7 and the channels
//   go idle. table contents are not cleared, every slot must be loaded before
//   a classify item reads it
module knn_three_class_classifier
    import knn3c_pkg::*;
#(
    parameter int NUM_REFS = NUM_REFS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // item input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [IDX_PORT_W-1:0]  s_entry_index,
    input  logic [AMP_W-1:0]       s_amplitude,
    input  logic [PER_W-1:0]       s_rr_period,
    input  logic [CLS_W-1:0]       s_entry_class,
    // result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LABEL_W-1:0]     m_class_label,
    output logic [SCORE_OUT_W-1:0] m_normal_score,
    output logic [SCORE_OUT_W-1:0] m_atrial_score,
    output logic [SCORE_OUT_W-1:0] m_ventricular_score,
    // k_neighbors write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [K_W-1:0]         cfg_data
);

    // controller to datapath commands and status back
    knn3c_cmd_t                  cmd;
    knn3c_stat_t                 stat;
    logic [$clog2(NUM_REFS)-1:0] rd_addr;

    // sequencer: scan, drain, vote, hand off
    knn3c_ctrl #(
        .NUM_REFS (NUM_REFS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_index (s_entry_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd_o         (cmd),
        .rd_addr_o     (rd_addr),
        .stat_i        (stat)
    );

    // table, distance pipeline, sorted list, scores, output register
    knn3c_dp #(
        .NUM_REFS (NUM_REFS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd_i               (cmd),
        .rd_addr_i           (rd_addr),
        .stat_o              (stat),
        .s_entry_index       (s_entry_index),
        .s_amplitude         (s_amplitude),
        .s_rr_period         (s_rr_period),
        .s_entry_class       (s_entry_class),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_class_label       (m_class_label),
        .m_normal_score      (m_normal_score),
        .m_atrial_score      (m_atrial_score),
        .m_ventricular_score (m_ventricular_score)
    );

endmodule

FILE: dv/knn_three_class_classifier_test.sv
`timescale 1ns / 1ps

module knn_three_class_classifier_test;
    import knn3c_pkg::*;

    localparam int REFS          = NUM_REFS_DEF;
    localparam int K_CAP         = REFS - 1;
    localparam int SLOT_TOP      = (1 << IDX_PORT_W) - 1;
    // settle time after a block, well past the longest classify
    localparam int SETTLE_CYCLES = 2 * (REFS + SLOT_TOP + 7);
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 20;
    localparam int PHASE_ITEMS   = 360;

    // class code that is stored and ranked but never votes
    localparam logic [CLS_W-1:0] CLASS_NONE = 2'd3;

    typedef struct packed {
        logic                  command;
        logic [IDX_PORT_W-1:0] slot;
        logic [AMP_W-1:0]      amp;
        logic [PER_W-1:0]      per;
        logic [CLS_W-1:0]      cls;
    } beat_t;

    typedef struct packed {
        logic [LABEL_W-1:0]     label;
        logic [SCORE_OUT_W-1:0] normal;
        logic [SCORE_OUT_W-1:0] atrial;
        logic [SCORE_OUT_W-1:0] ventricular;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [IDX_PORT_W-1:0]  s_entry_index;
    logic [AMP_W-1:0]       s_amplitude;
    logic [PER_W-1:0]       s_rr_period;
    logic [CLS_W-1:0]       s_entry_class;
    logic                   m_valid;
    logic                   m_ready;
    logic [LABEL_W-1:0]     m_class_label;
    logic [SCORE_OUT_W-1:0] m_normal_score;
    logic [SCORE_OUT_W-1:0] m_atrial_score;
    logic [SCORE_OUT_W-1:0] m_ventricular_score;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [K_W-1:0]         cfg_data;

    // shadow copy of the reference table and of k
    logic [AMP_W-1:0] tbl_amp [REFS];
    logic [PER_W-1:0] tbl_per [REFS];
    logic [CLS_W-1:0] tbl_cls [REFS];
    logic [K_W-1:0]   k_model;

    beat_t    pending_beats[$];
    verdict_t expected_verdicts[$];
    beat_t    cur;
    verdict_t head;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int unsigned n_loads    = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_classify = 0;
    int unsigned n_ties     = 0;
    int unsigned k_writes   = 0;

    knn_three_class_classifier #(
        .NUM_REFS(REFS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_entry_index      (s_entry_index),
        .s_amplitude        (s_amplitude),
        .s_rr_period        (s_rr_period),
        .s_entry_class      (s_entry_class),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_class_label      (m_class_label),
        .m_normal_score     (m_normal_score),
        .m_atrial_score     (m_atrial_score),
        .m_ventricular_score(m_ventricular_score),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // rank every entry by squared distance, lower slot first on equal distance,
    // and add rank*rank to the class of ranks 1..k
    function automatic verdict_t rank_and_vote(logic [AMP_W-1:0] amp, logic [PER_W-1:0] per);
        longint      dist_sq [REFS];
        longint      tally [3];
        longint      da;
        longint      dp;
        int unsigned k_eff;
        int unsigned rank;
        verdict_t    v;
        k_eff = (k_model > K_CAP) ? K_CAP : k_model;
        tally = '{0, 0, 0};
        for (int i = 0; i < REFS; i++) begin
            da = longint'(amp) - longint'(tbl_amp[i]);
            dp = longint'(per) - longint'(tbl_per[i]);
            dist_sq[i] = da * da + dp * dp;
        end
        for (int i = 0; i < REFS; i++) begin
            rank = 0;
            for (int j = 0; j < REFS; j++) begin
                if (dist_sq[j] < dist_sq[i] || (dist_sq[j] == dist_sq[i] && j < i)) rank++;
            end
            if (rank >= 1 && rank <= k_eff && tbl_cls[i] != CLASS_NONE)
                tally[tbl_cls[i]] += rank * rank;
        end
        if (tally[CLASS_NORMAL] > tally[CLASS_ATRIAL] &&
            tally[CLASS_NORMAL] > tally[CLASS_VENTRICULAR]) begin
            v.label = LABEL_NORMAL;
        end else if (tally[CLASS_ATRIAL] > tally[CLASS_NORMAL] &&
                     tally[CLASS_ATRIAL] > tally[CLASS_VENTRICULAR]) begin
            v.label = LABEL_ATRIAL;
        end else if (tally[CLASS_VENTRICULAR] > tally[CLASS_NORMAL] &&
                     tally[CLASS_VENTRICULAR] > tally[CLASS_ATRIAL]) begin
            v.label = LABEL_VENTRICULAR;
        end else begin
            v.label = LABEL_UNKNOWN;
        end
        for (int c = 0; c < 3; c++) begin
            if (tally[c] > SCORE_OUT_MAX) tally[c] = SCORE_OUT_MAX;
        end
        v.normal      = SCORE_OUT_W'(tally[CLASS_NORMAL]);
        v.atrial      = SCORE_OUT_W'(tally[CLASS_ATRIAL]);
        v.ventricular = SCORE_OUT_W'(tally[CLASS_VENTRICULAR]);
        return v;
    endfunction

    function automatic beat_t load_beat(int unsigned slot, logic [AMP_W-1:0] amp,
                                        logic [PER_W-1:0] per, logic [CLS_W-1:0] cls);
        beat_t b;
        b.command = CMD_LOAD;
        b.slot    = IDX_PORT_W'(slot);
        b.amp     = amp;
        b.per     = per;
        b.cls     = cls;
        return b;
    endfunction

    // slot and class are don't-care on a classify, so they carry noise
    function automatic beat_t classify_beat(logic [AMP_W-1:0] amp, logic [PER_W-1:0] per);
        beat_t b;
        b.command = CMD_CLASSIFY;
        b.slot    = IDX_PORT_W'($urandom_range(SLOT_TOP));
        b.amp     = amp;
        b.per     = per;
        b.cls     = CLS_W'($urandom_range(3));
        return b;
    endfunction

    // corner values often, so equal distances and extremes show up
    function automatic logic [AMP_W-1:0] random_coord();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return AMP_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // wait until every item is taken and every result is back
    task automatic drain_block();
        do @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_k(input logic [K_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        k_model = value;
        k_writes++;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned placed;
        int unsigned roll;
        beat_t       b;
        placed = 0;
        while (placed < count) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                b = classify_beat(random_coord(), random_coord());
            end else if (roll < 92) begin
                b = load_beat($urandom_range(K_CAP), random_coord(), random_coord(),
                              CLS_W'($urandom_range(3)));
            end else begin
                b = load_beat($urandom_range(SLOT_TOP, REFS), random_coord(), random_coord(),
                              CLS_W'($urandom_range(3)));
            end
            pending_beats.push_back(b);
            if (b.command == CMD_CLASSIFY || b.slot < REFS) begin
                placed++;
                // sender holds off mid-phase until the pipe is empty
                if (placed == count / 2) drain_block();
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                if (cur.command == CMD_LOAD) begin
                    n_loads++;
                    if (cur.slot < REFS) begin
                        tbl_amp[cur.slot] = cur.amp;
                        tbl_per[cur.slot] = cur.per;
                        tbl_cls[cur.slot] = cur.cls;
                    end else begin
                        n_dropped++;
                    end
                end else begin
                    n_classify++;
                    expected_verdicts.push_back(rank_and_vote(cur.amp, cur.per));
                end
            end
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur = pending_beats.pop_front();
                s_valid       <= 1'b1;
                s_command     <= cur.command;
                s_entry_index <= cur.slot;
                s_amplitude   <= cur.amp;
                s_rr_period   <= cur.per;
                s_entry_class <= cur.cls;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transfer, expected none, actual label %0d",
                             $time, m_class_label);
            end else begin
                head = expected_verdicts.pop_front();
                if (head.label == LABEL_UNKNOWN) n_ties++;
                check_field("class_label", head.label, m_class_label);
                check_field("normal_score", head.normal, m_normal_score);
                check_field("atrial_score", head.atrial, m_atrial_score);
                check_field("ventricular_score", head.ventricular, m_ventricular_score);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [CLS_W-1:0] cls;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_LOAD;
        s_entry_index = '0;
        s_amplitude   = '0;
        s_rr_period   = '0;
        s_entry_class = CLASS_NORMAL;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        k_model       = K_RESET;
        send_idle_pct = 18;
        recv_idle_pct = 56;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // table on the diagonal so a sample at the origin ranks by slot;
        // slots 1 and 2 never vote, normal 3,4 against atrial 5 ties at k=5
        for (int i = 0; i < REFS; i++) begin
            if (i == 1 || i == 2) cls = CLASS_NONE;
            else if (i <= 4) cls = CLASS_NORMAL;
            else if (i == 5) cls = CLASS_ATRIAL;
            else cls = CLS_W'(i % 4);
            if (i == K_CAP)
                pending_beats.push_back(load_beat(i, '1, '1, cls));
            else
                pending_beats.push_back(load_beat(i, AMP_W'(i * 1600), PER_W'(i * 1600), cls));
        end

        // loads past the table end must not land anywhere
        pending_beats.push_back(load_beat(REFS, 16'h0001, 16'h0001, CLASS_ATRIAL));
        pending_beats.push_back(load_beat(SLOT_TOP, '0, '0, CLASS_VENTRICULAR));
        pending_beats.push_back(classify_beat('0, '0));
        pending_beats.push_back(classify_beat('1, '1));
        pending_beats.push_back(classify_beat('1, '0));
        pending_beats.push_back(classify_beat('0, '1));
        // equal distance to slots 0 and 1
        pending_beats.push_back(classify_beat(16'd800, 16'd800));
        drain_block();

        write_k(K_W'(5));
        pending_beats.push_back(classify_beat('0, '0));
        drain_block();
        write_k('0);
        pending_beats.push_back(classify_beat('0, '0));
        pending_beats.push_back(classify_beat(16'h8000, 16'h1234));
        drain_block();
        write_k('1);
        pending_beats.push_back(classify_beat('0, '0));
        pending_beats.push_back(classify_beat('1, '1));
        drain_block();
        write_k(K_W'(K_CAP));
        pending_beats.push_back(classify_beat('0, '0));
        drain_block();
        write_k(K_W'(1));
        pending_beats.push_back(classify_beat('0, '0));
        pending_beats.push_back(classify_beat(16'd30000, 16'd20000));
        drain_block();

        write_k(K_W'($urandom_range(K_CAP, 1)));
        run_random(PHASE_ITEMS);
        drain_block();

        send_idle_pct = 56;
        recv_idle_pct = 18;
        write_k(K_W'($urandom_range(SLOT_TOP, REFS)));
        run_random(PHASE_ITEMS);
        drain_block();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_k(K_W'($urandom_range(8, 2)));
        run_random(PHASE_ITEMS);
        drain_block();

        $display("covered %0d loads (%0d past the table end) and %0d classifications",
                 n_loads, n_dropped, n_classify);
        $display("%0d results were ties, over %0d k settings", n_ties, k_writes);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
